// ===== sv/b64_pkg.sv =====
// b64_pkg: shared types, character constants and alphabet functions
// for the base64 stream codec. No dependencies.
package b64_pkg;

  // one result item as held in the output buffer
  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
    logic       stop;
  } res_t;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
  localparam logic [7:0] CHAR_UA    = 8'h41; // 'A'
  localparam logic [7:0] CHAR_UZ    = 8'h5A; // 'Z'
  localparam logic [7:0] CHAR_LA    = 8'h61; // 'a'
  localparam logic [7:0] CHAR_LZ    = 8'h7A; // 'z'
  localparam logic [7:0] CHAR_D0    = 8'h30; // '0'
  localparam logic [7:0] CHAR_D9    = 8'h39; // '9'

  // alphabet character for a sextet
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26)      c = CHAR_UA + {2'b00, s};
    else if (s < 6'd52) c = CHAR_LA + {2'b00, s} - 8'd26;
    else if (s < 6'd62) c = CHAR_D0 + {2'b00, s} - 8'd52;
    else if (s == 6'd62) c = CHAR_PLUS;
    else                c = CHAR_SLASH;
    return c;
  endfunction

  // sextet of a character, bit 6 set for pad and anything outside the alphabet
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [7:0] v;
    logic       bad;
    v   = 8'd0;
    bad = 1'b0;
    if (c >= CHAR_UA && c <= CHAR_UZ)      v = c - CHAR_UA;
    else if (c >= CHAR_LA && c <= CHAR_LZ) v = c - CHAR_LA + 8'd26;
    else if (c >= CHAR_D0 && c <= CHAR_D9) v = c - CHAR_D0 + 8'd52;
    else if (c == CHAR_PLUS)               v = 8'd62;
    else if (c == CHAR_SLASH)              v = 8'd63;
    else                                   bad = 1'b1;
    return {bad, v[5:0]};
  endfunction

endpackage

// ===== sv/base64_stream_codec.sv =====
// base64_stream_codec: one-byte-per-item base64 encoder and decoder
// with a four-entry result buffer. Depends on b64_pkg.
// The first result of an item is offered the cycle after it is accepted.
// An item is taken only while the buffer is empty or its last result leaves,
// so no new item is taken while two or more results are still waiting.
// Reset (rst_n low, synchronous): encode direction, empty group, empty buffer.
module base64_stream_codec
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_data_valid,
  output logic       out_last,
  output logic       out_stopped_early
);

  logic        dir_r;
  logic [23:0] grp_bits_r, grp_bits_nxt;
  logic [1:0]  grp_cnt_r, grp_cnt_nxt;
  logic        halted_r, halted_nxt;
  res_t        buf_r [4];
  res_t        buf_nxt [4];
  logic [2:0]  res_cnt_r, res_cnt_nxt;

  res_t        res_new [4];
  logic [2:0]  n_new;

  logic in_acc, out_pop, cfg_acc;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = (res_cnt_r != 3'd0);
  assign out_pop   = out_valid && out_ready;
  assign in_ready  = (res_cnt_r == 3'd0) || ((res_cnt_r == 3'd1) && out_ready);
  assign in_acc    = in_valid && in_ready;

  // result item for one accepted item
  always_comb begin
    logic [1:0]  c;
    logic [23:0] bits;
    logic        h;
    logic [6:0]  sx;
    logic [2:0]  chars;
    logic        full;
    res_new[0] = '0;
    res_new[1] = '0;
    res_new[2] = '0;
    res_new[3] = '0;
    n_new      = 3'd0;
    c          = grp_cnt_r;
    bits       = grp_bits_r;
    h          = halted_r;
    sx         = b64_sextet(in_byte);
    chars      = 3'd0;
    full       = 1'b0;
    if (dir_r == DIR_ENCODE) begin
      // encode: pack the byte, emit four characters on a full group or the end
      if (c == 2'd3) begin
        c    = 2'd0;
        bits = '0;
      end
      case (c)
        2'd0:    bits = bits | {in_byte, 16'h0000};
        2'd1:    bits = bits | {8'h00, in_byte, 8'h00};
        2'd2:    bits = bits | {16'h0000, in_byte};
        default: bits = bits;
      endcase
      if (c == 2'd2 || in_last) begin
        chars = {1'b0, c} + 3'd2;
        for (int k = 0; k < 4; k++) begin
          res_new[k].data   = (3'(k) < chars) ? b64_char(bits[23-6*k -: 6]) : CHAR_PAD;
          res_new[k].dvalid = 1'b1;
        end
        n_new = 3'd4;
        bits  = '0;
        c     = 2'd0;
      end else begin
        c = c + 2'd1;
      end
    end else begin
      // decode: add a sextet unless halted (pad or a bad character halts), emit three bytes per full group
      if (!h) begin
        if (sx[6]) begin
          h = 1'b1;
        end else begin
          case (c)
            2'd0:    bits = bits | {sx[5:0], 18'h0};
            2'd1:    bits = bits | {6'h0, sx[5:0], 12'h0};
            2'd2:    bits = bits | {12'h0, sx[5:0], 6'h0};
            default: bits = bits | {18'h0, sx[5:0]};
          endcase
          if (c == 2'd3) begin
            full = 1'b1;
            c    = 2'd0;
          end else begin
            c = c + 2'd1;
          end
        end
      end
      if (full) begin
        for (int k = 0; k < 3; k++) begin
          res_new[k].data   = bits[23-8*k -: 8];
          res_new[k].dvalid = 1'b1;
        end
        n_new = 3'd3;
        bits  = '0;
      end else if (in_last && c != 2'd0) begin
        // flush a partial group as count-1 bytes
        for (int k = 0; k < 3; k++) begin
          res_new[k].data   = bits[23-8*k -: 8];
          res_new[k].dvalid = 1'b1;
          res_new[k].stop   = h;
        end
        n_new = {1'b0, c} - 3'd1;
      end
    end
    // end of message: marker if nothing else, tag the final result
    if (in_last) begin
      if (n_new == 3'd0) begin
        res_new[0].data   = 8'h00;
        res_new[0].dvalid = 1'b0;
        res_new[0].stop   = (dir_r == DIR_DECODE) ? h : 1'b0;
        n_new             = 3'd1;
      end
      res_new[n_new[1:0] - 2'd1].last = 1'b1;
      bits = '0;
      c    = 2'd0;
      h    = 1'b0;
    end
    grp_bits_nxt = bits;
    grp_cnt_nxt  = c;
    halted_nxt   = h;
  end

  // result buffer: load on accept, shift on pop
  always_comb begin
    buf_nxt     = buf_r;
    res_cnt_nxt = res_cnt_r;
    if (out_pop) begin
      buf_nxt[0]  = buf_r[1];
      buf_nxt[1]  = buf_r[2];
      buf_nxt[2]  = buf_r[3];
      res_cnt_nxt = res_cnt_r - 3'd1;
    end
    if (in_acc) begin
      buf_nxt     = res_new;
      res_cnt_nxt = n_new;
    end
  end

  // control and group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r      <= DIR_ENCODE;
      grp_bits_r <= '0;
      grp_cnt_r  <= 2'd0;
      halted_r   <= 1'b0;
      res_cnt_r  <= 3'd0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
      if (cfg_acc) begin
        dir_r      <= cfg_direction;
        grp_bits_r <= '0;
        grp_cnt_r  <= 2'd0;
        halted_r   <= 1'b0;
      end else if (in_acc) begin
        grp_bits_r <= grp_bits_nxt;
        grp_cnt_r  <= grp_cnt_nxt;
        halted_r   <= halted_nxt;
      end
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_byte          = buf_r[0].data;
  assign out_data_valid    = buf_r[0].dvalid;
  assign out_last          = buf_r[0].last;
  assign out_stopped_early = buf_r[0].stop;

  // checks
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (res_cnt_r <= 3'd1))
    else $error("item accepted while buffer holds more than one result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> (res_cnt_r != 3'd0) && (grp_cnt_r == 2'd0) && !halted_r)
    else $error("final item left no result or kept group state");

  a_encode_count: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_r == DIR_ENCODE) |-> (grp_cnt_r != 2'd3) && !halted_r)
    else $error("encode group state out of range");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (grp_cnt_r == 2'd0) && (grp_bits_r == 24'h0) && !halted_r)
    else $error("direction write did not clear the group");

endmodule
